// File: src/billboard_quad_vertex_generator_assert.svh
// Assertion macros used by the billboard quad generator control module
`ifndef BILLBOARD_QUAD_VERTEX_GENERATOR_ASSERT_SVH
`define BILLBOARD_QUAD_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication
`define BBQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbq assertion failed");

// next-cycle implication
`define BBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbq assertion failed");

`endif

// File: src/bbq_pkg.sv
// Types, codes and helpers of the billboard quad vertex generator
`timescale 1ns / 1ps
package bbq_pkg;
  localparam int COORD_W = 20;
  localparam int CNT_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int DIST_W  = 44;
  localparam int CFG_W   = 60;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [2:0] CFG_CYLINDRICAL = 3'd0;
  localparam logic [2:0] CFG_SORT_EN     = 3'd1;
  localparam logic [2:0] CFG_CAMERA      = 3'd2;
  localparam logic [2:0] CFG_UP          = 3'd3;
  localparam logic [2:0] CFG_RIGHT       = 3'd4;

  localparam logic [CFG_W-1:0] UP_RESET    = 60'd137438953472;
  localparam logic [CFG_W-1:0] RIGHT_RESET = 60'd131072;
  localparam logic signed [COORD_W-1:0] UNIT_ONE = 20'sd131072;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    coord_t w;
    coord_t h;
  } quad_t;

  typedef enum logic [2:0] {ST_IDLE, ST_DIST, ST_SORT, ST_GEN, ST_EMIT} state_t;

  typedef struct packed {
    logic              store_clear;
    logic              append;
    logic              dist_step;
    logic              sort_step;
    logic              phase;
    logic              gen_step;
    logic              emit;
    logic              last;
    logic [SLOT_W-1:0] idx;
    logic [1:0]        sub;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             sort_en;
    logic             out_free;
  } status_t;

  function automatic coord_t lane(input logic [CFG_W-1:0] v, input logic [1:0] k);
    coord_t r;
    case (k)
      2'd0:    r = v[19:0];
      2'd1:    r = v[39:20];
      default: r = v[59:40];
    endcase
    return r;
  endfunction
endpackage

// File: src/bbq_quad_if.sv
// Input request channel carrying one quad command
`timescale 1ns / 1ps
interface bbq_quad_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  bbq_pkg::coord_t      center_x;
  bbq_pkg::coord_t      center_y;
  bbq_pkg::coord_t      center_z;
  bbq_pkg::coord_t      half_width;
  bbq_pkg::coord_t      half_height;
  modport source (output valid, op, center_x, center_y, center_z, half_width, half_height,
                  input ready);
  modport sink (input valid, op, center_x, center_y, center_z, half_width, half_height,
                output ready);
endinterface

// File: src/bbq_vertex_if.sv
// Output request channel carrying one vertex
`timescale 1ns / 1ps
interface bbq_vertex_if;
  logic                        valid;
  logic                        ready;
  bbq_pkg::coord_t             pos_x;
  bbq_pkg::coord_t             pos_y;
  bbq_pkg::coord_t             pos_z;
  logic [bbq_pkg::SLOT_W-1:0]  slot;
  logic [1:0]                  corner;
  logic                        last;
  modport source (output valid, pos_x, pos_y, pos_z, slot, corner, last, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, slot, corner, last, output ready);
endinterface

// File: src/bbq_ctrl.sv
// Sequencer for clear, append, distance, sort, corner generation and emission
`timescale 1ns / 1ps
`include "billboard_quad_vertex_generator_assert.svh"
module bbq_ctrl #(
  parameter int MAX_QUADS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  output logic             in_ready,
  input  bbq_pkg::status_t status,
  output bbq_pkg::cmd_t    cmd
);
  bbq_pkg::state_t                state, state_next;
  logic [bbq_pkg::SLOT_W-1:0]     idx, idx_next;
  logic [1:0]                     sub, sub_next;
  logic [bbq_pkg::SLOT_W-1:0]     pass, pass_next;
  logic                           at_last;

  assign at_last = ({1'b0, idx} == status.count - bbq_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbq_pkg::ST_IDLE;
      idx   <= '0;
      sub   <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      sub   <= sub_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    sub_next   = sub;
    pass_next  = pass;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.sub    = sub;
    cmd.phase  = pass[0];
    case (state)
      bbq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            bbq_pkg::OP_CLEAR:  cmd.store_clear = 1'b1;
            bbq_pkg::OP_APPEND: cmd.append = 1'b1;
            bbq_pkg::OP_UPDATE: begin
              if (status.count != '0) begin
                idx_next   = '0;
                sub_next   = '0;
                state_next = status.sort_en ? bbq_pkg::ST_DIST : bbq_pkg::ST_GEN;
              end
            end
            default: ;
          endcase
        end
      end
      bbq_pkg::ST_DIST: begin
        cmd.dist_step = 1'b1;
        if (sub == 2'd2) begin
          sub_next = '0;
          if (at_last) begin
            idx_next   = '0;
            pass_next  = '0;
            state_next = bbq_pkg::ST_SORT;
          end else begin
            idx_next = idx + 1'b1;
          end
        end else begin
          sub_next = sub + 1'b1;
        end
      end
      bbq_pkg::ST_SORT: begin
        cmd.sort_step = 1'b1;
        if (pass == bbq_pkg::SLOT_W'(MAX_QUADS - 1)) begin
          sub_next   = '0;
          state_next = bbq_pkg::ST_GEN;
        end else begin
          pass_next = pass + 1'b1;
        end
      end
      bbq_pkg::ST_GEN: begin
        cmd.gen_step = 1'b1;
        if (sub == 2'd3) begin
          sub_next   = '0;
          state_next = bbq_pkg::ST_EMIT;
        end else begin
          sub_next = sub + 1'b1;
        end
      end
      bbq_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = at_last && (sub == 2'd3);
          sub_next = sub + 1'b1;
          if (sub == 2'd3) begin
            if (at_last) begin
              state_next = bbq_pkg::ST_IDLE;
            end else begin
              idx_next   = idx + 1'b1;
              state_next = bbq_pkg::ST_GEN;
            end
          end
        end
      end
      default: state_next = bbq_pkg::ST_IDLE;
    endcase
  end

  `BBQ_ASSERT_NOW(a_ready_idle, clk, rst, in_ready, state == bbq_pkg::ST_IDLE)
  `BBQ_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, status.out_free)
  `BBQ_ASSERT_NOW(a_idx_range, clk, rst, state != bbq_pkg::ST_IDLE,
                  {1'b0, idx} < status.count)
  `BBQ_ASSERT_NEXT(a_last_idle, clk, rst, cmd.last, state == bbq_pkg::ST_IDLE)
endmodule

// File: src/bbq_datapath.sv
// Quad store, configuration, distance and corner arithmetic, output register
`timescale 1ns / 1ps
module bbq_datapath #(
  parameter int MAX_QUADS  = 16,
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [bbq_pkg::CFG_W-1:0]    cfg_wdata,
  input  bbq_pkg::quad_t               in_quad,
  input  bbq_pkg::cmd_t                cmd,
  output bbq_pkg::status_t             status,
  bbq_vertex_if.source                 out_v
);
  localparam int IW      = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;
  localparam int OUT_B   = (COORD_BITS > 20) ? 20 : COORD_BITS;
  localparam int SAT_HI  = (1 << (OUT_B - 1)) - 1;
  localparam int SAT_LO  = -(1 << (OUT_B - 1));

  logic                          cylindrical_mode, depth_sort_enable;
  logic [bbq_pkg::CFG_W-1:0]     camera_position, up_vector, right_vector;
  logic [bbq_pkg::CNT_W-1:0]     count;
  bbq_pkg::quad_t                quads [MAX_QUADS];
  logic [bbq_pkg::DIST_W-1:0]    qdist [MAX_QUADS];
  logic [bbq_pkg::DIST_W-1:0]    acc;

  bbq_pkg::quad_t                cur;
  bbq_pkg::coord_t               c_lane, cam_lane, r_lane, u_lane, sz_w, sz_h;
  logic signed [20:0]            diff;
  logic [41:0]                   sq;

  logic signed [39:0]            rprod, uprod;
  bbq_pkg::coord_t               cs;
  logic [1:0]                    kreg;
  logic signed [41:0]            cs_x, r_x, u_x;
  logic signed [41:0]            s [4];
  bbq_pkg::coord_t               sat [4];
  bbq_pkg::coord_t               vert [4][3];

  assign cur    = quads[cmd.idx[IW-1:0]];
  assign sz_w   = cur.w;
  assign sz_h   = cur.h;
  assign c_lane = bbq_pkg::lane({cur.cz, cur.cy, cur.cx}, cmd.sub);
  assign cam_lane = bbq_pkg::lane(camera_position, cmd.sub);
  assign r_lane = bbq_pkg::lane(right_vector, cmd.sub);
  assign u_lane = cylindrical_mode ? ((cmd.sub == 2'd1) ? bbq_pkg::UNIT_ONE : '0)
                                   : bbq_pkg::lane(up_vector, cmd.sub);
  assign diff   = 21'(c_lane) - 21'(cam_lane);
  assign sq     = 42'(diff * diff);

  assign status.count    = count;
  assign status.sort_en  = depth_sort_enable;
  assign status.out_free = !out_v.valid || out_v.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cylindrical_mode  <= 1'b0;
      depth_sort_enable <= 1'b0;
      camera_position   <= '0;
      up_vector         <= bbq_pkg::UP_RESET;
      right_vector      <= bbq_pkg::RIGHT_RESET;
      count             <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bbq_pkg::CFG_CYLINDRICAL: cylindrical_mode  <= cfg_wdata[0];
          bbq_pkg::CFG_SORT_EN:     depth_sort_enable <= cfg_wdata[0];
          bbq_pkg::CFG_CAMERA:      camera_position   <= cfg_wdata;
          bbq_pkg::CFG_UP:          up_vector         <= cfg_wdata;
          bbq_pkg::CFG_RIGHT:       right_vector      <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.store_clear) begin
        count <= '0;
      end else if (cmd.append && count < bbq_pkg::CNT_W'(MAX_QUADS)) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && count < bbq_pkg::CNT_W'(MAX_QUADS)) begin
      quads[count[IW-1:0]] <= in_quad;
    end
    if (cmd.dist_step) begin
      acc <= (cmd.sub == 2'd0) ? 44'(sq) : acc + 44'(sq);
      if (cmd.sub == 2'd2) begin
        qdist[cmd.idx[IW-1:0]] <= acc + 44'(sq);
      end
    end
    if (cmd.sort_step) begin
      for (int a = 0; a < MAX_QUADS - 1; a++) begin
        if (a[0] == cmd.phase && bbq_pkg::CNT_W'(a + 1) < count && qdist[a] < qdist[a + 1]) begin
          quads[a]      <= quads[a + 1];
          quads[a + 1]  <= quads[a];
          qdist[a]      <= qdist[a + 1];
          qdist[a + 1]  <= qdist[a];
        end
      end
    end
  end

  assign cs_x = 42'(cs) <<< 17;
  assign r_x  = 42'(rprod);
  assign u_x  = 42'(uprod);
  assign s[0] = cs_x - (r_x + u_x);
  assign s[1] = cs_x + (r_x - u_x);
  assign s[2] = cs_x + (r_x + u_x);
  assign s[3] = cs_x - (r_x - u_x);

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic signed [41:0] b;
      logic signed [24:0] q;
      b = s[j] + 42'sd65536;
      q = 25'(b >>> 17);
      if (q > 25'(SAT_HI))      sat[j] = 20'(SAT_HI);
      else if (q < 25'(SAT_LO)) sat[j] = 20'(SAT_LO);
      else                      sat[j] = q[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_step) begin
      if (cmd.sub != 2'd3) begin
        rprod <= r_lane * sz_w;
        uprod <= u_lane * sz_h;
        cs    <= c_lane;
        kreg  <= cmd.sub;
      end
      if (cmd.sub != 2'd0) begin
        for (int j = 0; j < 4; j++) vert[j][kreg] <= sat[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v.valid <= 1'b0;
    end else if (cmd.emit) begin
      out_v.valid <= 1'b1;
    end else if (out_v.ready) begin
      out_v.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_v.pos_x  <= vert[cmd.sub][0];
      out_v.pos_y  <= vert[cmd.sub][1];
      out_v.pos_z  <= vert[cmd.sub][2];
      out_v.slot   <= cmd.idx;
      out_v.corner <= cmd.sub;
      out_v.last   <= cmd.last;
    end
  end
endmodule

// File: src/billboard_quad_vertex_generator.sv
// Clear and append are taken while idle; an update without sorting builds a quad's
// corners in the GEN state, then emits its four vertices in EMIT, stalling on a full output.
// With sorting, the single distance multiplier first finds each quad's squared camera
// distance, then odd-even exchange passes sort the quads before the first vertex.
// Throughput is set by the one shared corner multiplier pair and the output register.
// Synchronous active-high reset empties the store and loads register defaults.
`timescale 1ns / 1ps
module billboard_quad_vertex_generator #(
  parameter int MAX_QUADS  = 16,
  parameter int COORD_BITS = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [bbq_pkg::CFG_W-1:0]  cfg_wdata,
  bbq_quad_if.sink                   in_q,
  bbq_vertex_if.source               out_v
);
  bbq_pkg::cmd_t    cmd;
  bbq_pkg::status_t status;
  bbq_pkg::quad_t   in_quad;

  assign in_quad = '{cx: in_q.center_x, cy: in_q.center_y, cz: in_q.center_z,
                     w: in_q.half_width, h: in_q.half_height};

  bbq_ctrl #(.MAX_QUADS(MAX_QUADS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_q.valid),
    .in_op    (in_q.op),
    .in_ready (in_q.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bbq_datapath #(.MAX_QUADS(MAX_QUADS), .COORD_BITS(COORD_BITS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_quad   (in_quad),
    .cmd       (cmd),
    .status    (status),
    .out_v     (out_v)
  );
endmodule
